// File: rtl/lpht_pkg.sv
// Shared types and constants for the linear-probing hash table.
// No dependencies; imported by lpht_mod, linear_probe_hash_table_unit, lpht_checker and tb.
package lpht_pkg;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int SEL_W    = 4;
   localparam int STATUS_W = 2;
   localparam int PROBE_W  = 5;
   localparam int VALUE_W  = 32;

   localparam int PROBE_SAT = (1 << PROBE_W) - 1;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_ZERO = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_READ,
      S_CHECK,
      S_RDSLOT
   } state_type;

endpackage

// File: rtl/linear_probe_hash_table_unit.sv
// Linear-probing hash table over TABLE_SLOTS key slots in one memory; uses lpht_pkg, lpht_mod.
// Key zero, an unused operation and an out-of-range read answer straight from idle through
// the result registers; an in-range read first reads the slot memory. Insert and search form
// the home slot in lpht_mod, then probe one slot at a time through the single memory read port.
// Throughput: one item at a time, busy high until the answer leaves (never for an item answered
// straight from idle); the receiver cannot stall. Reset: a clearing pass empties every slot, busy high.
module linear_probe_hash_table_unit #(
   parameter int TABLE_SLOTS = 16,
   parameter int KEY_BITS    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lpht_pkg::OP_W-1:0]     req_operation,
   input  logic [lpht_pkg::KEY_W-1:0]    req_key,
   input  logic [lpht_pkg::SEL_W-1:0]    req_slot_select,
   output logic                          rsp_valid,
   output logic [lpht_pkg::STATUS_W-1:0] rsp_status,
   output logic [lpht_pkg::SEL_W-1:0]    rsp_slot_index,
   output logic [lpht_pkg::PROBE_W-1:0]  rsp_probe_count,
   output logic [lpht_pkg::VALUE_W-1:0]  rsp_slot_value
);
   import lpht_pkg::*;

   localparam int KB   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
   localparam int IW   = $clog2(TABLE_SLOTS);
   localparam int PW   = $clog2(TABLE_SLOTS + 1);
   localparam int SELW = ((IW > SEL_W) ? IW : SEL_W) + 1;
   localparam int OW   = (IW > SEL_W) ? IW : SEL_W;
   localparam int QW   = (PW > PROBE_W) ? PW : PROBE_W;

   logic [KB-1:0] slot_mem [TABLE_SLOTS];

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [KB-1:0]    key_ff, key_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [PW-1:0]    probe_ff, probe_in;
   logic [IW-1:0]    clr_ff, clr_in;
   logic [KB-1:0]    rd_data_ff;
   logic [SEL_W-1:0] sel_ff, sel_in;
   logic             hash_go_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [SEL_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [PROBE_W-1:0] rsp_probe_ff, rsp_probe_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [KB-1:0]     wr_data;
   logic [IW-1:0]     rd_addr;

   logic              mod_start, mod_done;
   logic [IW-1:0]     mod_rem;

   op_type            req_op;
   logic [KB-1:0]     req_key_m;
   logic [SELW-1:0]   sel_ext;
   logic              sel_ok;
   logic [PW-1:0]     probe_n;
   logic [QW-1:0]     probe_q;
   logic [OW-1:0]     idx_wide;
   logic              hit;

   lpht_mod #(
      .DIVISOR  (TABLE_SLOTS),
      .KEY_BITS (KB)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (key_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign req_op    = op_type'(req_operation);
   assign req_key_m = KB'(req_key);
   assign sel_ext   = SELW'(req_slot_select);
   assign sel_ok    = sel_ext < SELW'(TABLE_SLOTS);
   assign probe_n   = probe_ff + 1'b1;
   assign probe_q   = QW'(probe_n);
   assign idx_wide  = OW'(idx_ff);
   assign hit       = (op_ff == OP_INSERT) ? (rd_data_ff == '0) : (rd_data_ff == key_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      probe_in      = probe_ff;
      clr_in        = clr_ff;
      sel_in        = sel_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_probe_in  = rsp_probe_ff;
      rsp_value_in  = rsp_value_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = key_ff;
      rd_addr       = idx_ff;
      mod_start     = 1'b0;
      busy          = 1'b1;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IW'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            busy    = 1'b0;
            rd_addr = IW'(sel_ext);
            if (start) begin
               op_in  = req_op;
               key_in = req_key_m;
               sel_in = req_slot_select;
               if (req_op == OP_READ) begin
                  if (sel_ok) begin
                     state_in = S_RDSLOT;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_MISS;
                     rsp_slot_in   = req_slot_select;
                     rsp_probe_in  = '0;
                     rsp_value_in  = '0;
                  end
               end else if (req_op == OP_NONE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_MISS;
                  rsp_slot_in   = '0;
                  rsp_probe_in  = '0;
                  rsp_value_in  = '0;
               end else if (req_key_m == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_ZERO;
                  rsp_slot_in   = '0;
                  rsp_probe_in  = '0;
                  rsp_value_in  = '0;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            mod_start = hash_go_ff;
            if (mod_done) begin
               idx_in   = mod_rem;
               probe_in = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (hit) begin
               wr_en         = (op_ff == OP_INSERT);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_slot_in   = idx_wide[SEL_W-1:0];
               rsp_probe_in  = (probe_q > QW'(PROBE_SAT)) ? PROBE_W'(PROBE_SAT)
                                                          : probe_q[PROBE_W-1:0];
               rsp_value_in  = VALUE_W'(key_ff);
               state_in      = S_IDLE;
            end else if (probe_n == PW'(TABLE_SLOTS)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_MISS;
               rsp_slot_in   = '0;
               rsp_probe_in  = (probe_q > QW'(PROBE_SAT)) ? PROBE_W'(PROBE_SAT)
                                                          : probe_q[PROBE_W-1:0];
               rsp_value_in  = '0;
               state_in      = S_IDLE;
            end else begin
               probe_in = probe_n;
               idx_in   = (idx_ff == IW'(TABLE_SLOTS - 1)) ? '0 : idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_RDSLOT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_slot_in   = sel_ff;
            rsp_probe_in  = '0;
            rsp_value_in  = VALUE_W'(rd_data_ff);
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // kick the remainder unit in the cycle after accept, once the key is held
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_go_ff <= 1'b0;
      end else begin
         hash_go_ff <= (state_ff == S_IDLE) && (state_in == S_HASH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      probe_ff      <= probe_in;
      sel_ff        <= sel_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_probe_ff  <= rsp_probe_in;
      rsp_value_ff  <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_probe_count = rsp_probe_ff;
   assign rsp_slot_value  = rsp_value_ff;

endmodule

// File: rtl/lpht_mod.sv
// Home-slot unit: dividend mod DIVISOR by reciprocal multiplication, then a registered subtract.
// Depends on lpht_pkg (nothing used beyond the import convention).
module lpht_mod #(
   parameter int DIVISOR  = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [KEY_BITS-1:0]         dividend,
   output logic                        done,
   output logic [$clog2(DIVISOR)-1:0]  remainder
);
   import lpht_pkg::*;

   localparam int IW  = $clog2(DIVISOR);
   localparam int SH  = KEY_BITS + IW;
   localparam int PRW = 2 * KEY_BITS + 1;
   localparam logic [KEY_BITS:0] RECIP =
      (KEY_BITS+1)'(((64'd1 << SH) / 64'(DIVISOR)) + 64'd1);

   logic                mul_go_ff, mul_go_in;
   logic                sub_go_ff, sub_go_in;
   logic                done_ff, done_in;
   logic [KEY_BITS-1:0] num_ff, num_in;
   logic [PRW-1:0]      prod_ff, prod_in;
   logic [IW-1:0]       rem_ff, rem_in;
   logic [KEY_BITS-1:0] quot;

   always_comb begin
      mul_go_in = start;
      sub_go_in = mul_go_ff;
      done_in   = sub_go_ff;
      num_in    = start ? dividend : num_ff;
      prod_in   = mul_go_ff ? PRW'(num_ff) * PRW'(RECIP) : prod_ff;
      quot      = KEY_BITS'(prod_ff >> SH);
      rem_in    = sub_go_ff ? IW'(num_ff - KEY_BITS'(quot * KEY_BITS'(DIVISOR))) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_go_ff <= 1'b0;
         sub_go_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         mul_go_ff <= mul_go_in;
         sub_go_ff <= sub_go_in;
         done_ff   <= done_in;
      end
      num_ff  <= num_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: tb/lpht_checker.sv
// Result checker for linear_probe_hash_table_unit: watches the request and result ports,
// predicts each answer from its own copy of the slot store and compares field by field.
// Depends on lpht_pkg.
module lpht_checker
   import lpht_pkg::*;
#(
   parameter int TABLE_SLOTS = 16,
   parameter int KEY_BITS    = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [SEL_W-1:0]    req_slot_select,
   input  logic                rsp_valid,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [SEL_W-1:0]    rsp_slot_index,
   input  logic [PROBE_W-1:0]  rsp_probe_count,
   input  logic [VALUE_W-1:0]  rsp_slot_value,
   output int                  fail_count,
   output int                  answers_pending
);

   typedef struct {
      status_type         status;
      logic [SEL_W-1:0]   slot;
      logic [PROBE_W-1:0] probes;
      logic [VALUE_W-1:0] value;
   } answer_type;

   logic [KEY_BITS-1:0] slot_keys [TABLE_SLOTS];
   answer_type          answers_due [$];

   initial begin
      fail_count      = 0;
      answers_pending = 0;
   end

   function automatic int clip_probes(input int n);
      return (n > PROBE_SAT) ? PROBE_SAT : n;
   endfunction

   function automatic answer_type probe_table(input op_type op,
                                              input logic [KEY_W-1:0] key_in,
                                              input logic [SEL_W-1:0] sel);
      answer_type          ans;
      logic [KEY_BITS-1:0] key;
      int                  home;
      int                  idx;
      ans = '{ST_MISS, '0, '0, '0};
      key = KEY_BITS'(key_in);
      if (op == OP_READ) begin
         ans.slot = sel;
         if (sel < TABLE_SLOTS) begin
            ans.status = ST_OK;
            ans.value  = VALUE_W'(slot_keys[sel]);
         end
         return ans;
      end
      if (op == OP_NONE) return ans;
      if (key == '0) begin
         ans.status = ST_ZERO;
         return ans;
      end
      home = int'(key % TABLE_SLOTS);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         idx = (home + i) % TABLE_SLOTS;
         if ((op == OP_INSERT && slot_keys[idx] == '0) ||
             (op == OP_SEARCH && slot_keys[idx] == key)) begin
            if (op == OP_INSERT) slot_keys[idx] = key;
            ans.status = ST_OK;
            ans.slot   = SEL_W'(idx);
            ans.probes = PROBE_W'(clip_probes(i + 1));
            ans.value  = VALUE_W'(key);
            return ans;
         end
      end
      ans.probes = PROBE_W'(clip_probes(TABLE_SLOTS));
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      answer_type head;
      if (reset) begin
         foreach (slot_keys[i]) slot_keys[i] = '0;
      end else begin
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_status), '0);
            end else begin
               head = answers_due.pop_front();
               if (rsp_status !== head.status)
                  report_mismatch("status", 32'(rsp_status), 32'(head.status));
               if (rsp_slot_index !== head.slot)
                  report_mismatch("slot_index", 32'(rsp_slot_index), 32'(head.slot));
               if (rsp_probe_count !== head.probes)
                  report_mismatch("probe_count", 32'(rsp_probe_count), 32'(head.probes));
               if (rsp_slot_value !== head.value)
                  report_mismatch("slot_value", 32'(rsp_slot_value), 32'(head.value));
            end
         end
         if (start && !busy)
            answers_due.push_back(probe_table(op_type'(req_operation), req_key,
                                              req_slot_select));
      end
      answers_pending = answers_due.size();
   end

endmodule

// File: tb/tb.sv
// Top of the testbench for linear_probe_hash_table_unit: clock, reset, directed and random
// items, and the verdict. Depends on lpht_pkg, the block and lpht_checker.
module tb;
   import lpht_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 1900;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_operation = '0;
   logic [KEY_W-1:0]    req_key = '0;
   logic [SEL_W-1:0]    req_slot_select = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [SEL_W-1:0]    rsp_slot_index;
   logic [PROBE_W-1:0]  rsp_probe_count;
   logic [VALUE_W-1:0]  rsp_slot_value;
   int                  fail_count;
   int                  answers_pending;
   int                  cycle_count = 0;
   bit                  idle_on = 1'b1;
   logic [KEY_W-1:0]    inserted_keys [$];

   linear_probe_hash_table_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_slot_select (req_slot_select),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_probe_count (rsp_probe_count),
      .rsp_slot_value  (rsp_slot_value)
   );

   lpht_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_slot_select (req_slot_select),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_probe_count (rsp_probe_count),
      .rsp_slot_value  (rsp_slot_value),
      .fail_count      (fail_count),
      .answers_pending (answers_pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL linear_probe_hash_table_unit");
         $finish;
      end
   end

   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return KEY_W'($urandom_range(1, 40));
         2: return {($urandom_range(0, 3) == 0) ? 28'($urandom()) : 28'h0,
                    4'($urandom_range(0, 15))};
         default: return {1'b1, 31'($urandom())};
      endcase
   endfunction

   task automatic send_item(input op_type op, input logic [KEY_W-1:0] key,
                            input logic [SEL_W-1:0] sel);
      int gap;
      gap = 0;
      while (idle_on && $urandom_range(0, 99) < 16) gap++;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_operation   <= op;
      req_key         <= key;
      req_slot_select <= sel;
      if (op == OP_INSERT && key != '0) inserted_keys.push_back(key);
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
   endtask

   initial begin
      int               pick;
      logic [KEY_W-1:0] k;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(OP_READ, $urandom(), 4'd0);
      send_item(OP_READ, $urandom(), 4'd15);
      send_item(OP_INSERT, '0, 4'd3);
      send_item(OP_SEARCH, '0, 4'd9);
      send_item(OP_NONE, $urandom(), 4'd7);
      send_item(OP_SEARCH, 32'd5, 4'd0);
      send_item(OP_INSERT, 32'hFFFF_FFFF, 4'd15);
      send_item(OP_INSERT, 32'h0000_001F, 4'd0);
      send_item(OP_INSERT, 32'h0000_0001, 4'd0);
      send_item(OP_INSERT, 32'h0000_0001, 4'd0);
      send_item(OP_INSERT, 32'h8000_0010, 4'd5);
      send_item(OP_SEARCH, 32'h0000_0001, 4'd0);
      send_item(OP_SEARCH, 32'h8000_0010, 4'd0);
      send_item(OP_SEARCH, 32'h0000_001F, 4'd15);
      send_item(OP_SEARCH, 32'h0000_0011, 4'd0);
      send_item(OP_READ, 32'hFFFF_FFFF, 4'd15);
      send_item(OP_READ, '0, 4'd3);
      send_item(OP_NONE, '0, 4'd0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on = !(n >= 800 && n < 1200);
         pick    = $urandom_range(0, 99);
         if (pick < 25) begin
            send_item(OP_INSERT, pick_key(), SEL_W'($urandom()));
         end else if (pick < 65) begin
            if (inserted_keys.size() > 0 && $urandom_range(0, 99) < 70)
               k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            else
               k = pick_key();
            send_item(OP_SEARCH, k, SEL_W'($urandom()));
         end else if (pick < 85) begin
            send_item(OP_READ, $urandom(), SEL_W'($urandom()));
         end else if (pick < 93) begin
            send_item($urandom_range(0, 1) ? OP_SEARCH : OP_INSERT, '0, SEL_W'($urandom()));
         end else begin
            send_item(OP_NONE, $urandom(), SEL_W'($urandom()));
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (answers_pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("PASS linear_probe_hash_table_unit");
      else
         $display("FAIL linear_probe_hash_table_unit");
      $finish;
   end

endmodule
